// ----- design/assert_macros.svh -----
// Assertion macros shared by the curve fit unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Least squares curve fit package
// Item types, accumulator widths and the Cramer permutation table.
// ----------------------------------------------------------------------------
package lsf_pkg;

	localparam int unsigned DEF_MAX_SAMPLES    = 1024;
	localparam int unsigned DEF_COEF_FRAC_BITS = 32;

	// accumulator widths (sized to hold every sum exactly at full capacity)
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned SX_W   = 23;
	localparam int unsigned SXY_W  = 34;
	localparam int unsigned SX3_W  = 45;
	localparam int unsigned SX4_W  = 56;
	localparam int unsigned MUL_W  = 24;
	// solver widths: operand magnitude, determinant/term width, coefficient
	localparam int unsigned OP_W   = 56;
	localparam int unsigned DW     = 112;
	localparam int unsigned COEF_W = 64;

	// column codes of the Cramer solve
	localparam logic [1:0] COL_CONST = 2'd0;
	localparam logic [1:0] COL_LIN   = 2'd1;
	localparam logic [1:0] COL_SQ    = 2'd2;
	localparam logic [1:0] COL_DET   = 2'd3;

	localparam logic [2:0] PERM_FIRST     = 3'd0;
	localparam logic [2:0] PERM_LIN_2ND   = 3'd2;
	localparam logic [2:0] PERM_LAST_QUAD = 3'd5;

	typedef struct packed {
		logic signed [11:0] x_sample;
		logic signed [11:0] y_sample;
		logic               last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] coef_constant;
		logic signed [63:0] coef_linear;
		logic signed [63:0] coef_square;
		logic               singular;
		logic               dropped_samples;
		logic [10:0]        point_count;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic signed [SX_W-1:0]  sum_x;
		logic signed [SX_W-1:0]  sum_y;
		logic signed [SXY_W-1:0] sum_xy;
		logic signed [SXY_W-1:0] sum_x_sq;
		logic signed [SX3_W-1:0] sum_x_sq_y;
		logic signed [SX3_W-1:0] sum_x_cube;
		logic signed [SX4_W-1:0] sum_x_fourth;
		logic                    overflow_seen;
	} sums_t;

	// column taken from each row by determinant term p
	function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] row);
		logic [5:0] cols;
		cols = 6'b000000;
		unique case (p)
			3'd0:    cols = {2'd2, 2'd1, 2'd0};
			3'd1:    cols = {2'd1, 2'd2, 2'd0};
			3'd2:    cols = {2'd2, 2'd0, 2'd1};
			3'd3:    cols = {2'd0, 2'd2, 2'd1};
			3'd4:    cols = {2'd1, 2'd0, 2'd2};
			3'd5:    cols = {2'd0, 2'd1, 2'd2};
			default: cols = 6'b000000;
		endcase
		unique case (row)
			2'd0:    return cols[1:0];
			2'd1:    return cols[3:2];
			default: return cols[5:4];
		endcase
	endfunction

	// odd permutations enter the determinant negated
	function automatic logic perm_neg(input logic [2:0] p);
		return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
	endfunction

endpackage

// ----- design/least_squares_curve_fit_unit.sv -----
// Least squares curve fit unit.
// Samples (x, y) arrive on in_valid/in_ready/in_data; each accepted item is
// added into exact power sums through one 24x24 multiplier, and no new item
// is taken until those sums are updated. An item flagged last_sample starts
// the solve and clears the sums for the next data set.
// The solve runs Cramer's rule on one shared wide adder: each determinant
// term is two shift-add multiplies of 56-bit magnitudes, and each coefficient
// a restoring division of the numerator by the determinant, then rounding.
// No item is taken while the solver works.
// The result item sits in an output register on out_valid/out_data until
// out_ready; a stalled receiver holds it there while new samples are still
// accepted, and a further solve waits for the register to drain.
// Samples beyond MAX_SAMPLES are dropped and reported with the result.
// fit_mode is written on cfg_wr_en and read when a solve starts.
// Reset clears the sums, fit_mode and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
// Least squares curve fit, top level
// Handshake, configuration register and output register around the units.
// ----------------------------------------------------------------------------
module least_squares_curve_fit_unit import lsf_pkg::*; #(
	parameter int unsigned MAX_SAMPLES    = DEF_MAX_SAMPLES,
	parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      fit_mode_q;
	logic      acc_busy;
	logic      acc_fire;
	sums_t     acc_snap;
	logic      sol_busy;
	logic      res_valid;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      out_free;

	assign in_ready  = !acc_busy && !sol_busy;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			fit_mode_q <= cfg_wr_data;
		end
	end

	lsf_accum #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_accum (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_valid && in_ready),
		.item  (in_data),
		.busy  (acc_busy),
		.fire  (acc_fire),
		.snap  (acc_snap)
	);

	lsf_solve #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_solve (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (acc_fire),
		.snap     (acc_snap),
		.mode     (fit_mode_q),
		.out_free (out_free),
		.busy     (sol_busy),
		.res_valid(res_valid),
		.res      (res)
	);

	// output register: load a new item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res;
		end
	end

endmodule

// ----- design/lsf_accum.sv -----
// ----------------------------------------------------------------------------
// Power sum accumulator
// Adds one sample into the exact power sums using a single shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsf_accum import lsf_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	output logic     busy,
	output logic     fire,
	output sums_t    snap
);

	typedef enum logic [1:0] {
		A_IDLE = 2'b01,
		A_RUN  = 2'b10
	} acc_state_t;

	localparam logic [2:0] STEP_SQ     = 3'd0;
	localparam logic [2:0] STEP_CUBE   = 3'd1;
	localparam logic [2:0] STEP_FOURTH = 3'd2;
	localparam logic [2:0] STEP_XY     = 3'd3;
	localparam logic [2:0] STEP_X2Y    = 3'd4;
	localparam logic [2:0] STEP_FIN    = 3'd5;

	acc_state_t               state_q;
	logic [2:0]               step_q;
	logic signed [11:0]       x_q;
	logic signed [11:0]       y_q;
	logic                     last_q;
	logic signed [MUL_W-1:0]  x2_q;
	sums_t                    sums_q;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	// select multiplier operands for the current step
	always_comb begin
		mul_a = MUL_W'(x_q);
		mul_b = MUL_W'(x_q);
		unique case (step_q)
			STEP_CUBE:   begin mul_a = x2_q;         mul_b = MUL_W'(x_q); end
			STEP_FOURTH: begin mul_a = x2_q;         mul_b = x2_q;        end
			STEP_XY:     begin mul_a = MUL_W'(x_q);  mul_b = MUL_W'(y_q); end
			STEP_X2Y:    begin mul_a = x2_q;         mul_b = MUL_W'(y_q); end
			default:     begin mul_a = MUL_W'(x_q);  mul_b = MUL_W'(x_q); end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign busy  = (state_q != A_IDLE);
	assign fire  = (state_q == A_RUN) && (step_q == STEP_FIN) && last_q;
	assign snap  = sums_q;

	// hold sample, step through the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			step_q  <= STEP_SQ;
			last_q  <= 1'b0;
			sums_q  <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						last_q  <= item.last_sample;
						state_q <= A_RUN;
						if (sums_q.count == CNT_W'(MAX_SAMPLES)) begin
							sums_q.overflow_seen <= 1'b1;
							step_q               <= STEP_FIN;
						end else begin
							step_q <= STEP_SQ;
						end
					end
				end
				A_RUN: begin
					unique case (step_q)
						STEP_SQ: begin
							sums_q.count    <= sums_q.count + 1'b1;
							sums_q.sum_x    <= sums_q.sum_x + SX_W'(x_q);
							sums_q.sum_y    <= sums_q.sum_y + SX_W'(y_q);
							sums_q.sum_x_sq <= sums_q.sum_x_sq + SXY_W'(mul_p);
							step_q          <= STEP_CUBE;
						end
						STEP_CUBE: begin
							sums_q.sum_x_cube <= sums_q.sum_x_cube + SX3_W'(mul_p);
							step_q            <= STEP_FOURTH;
						end
						STEP_FOURTH: begin
							sums_q.sum_x_fourth <= sums_q.sum_x_fourth + SX4_W'(mul_p);
							step_q              <= STEP_XY;
						end
						STEP_XY: begin
							sums_q.sum_xy <= sums_q.sum_xy + SXY_W'(mul_p);
							step_q        <= STEP_X2Y;
						end
						STEP_X2Y: begin
							sums_q.sum_x_sq_y <= sums_q.sum_x_sq_y + SX3_W'(mul_p);
							step_q            <= STEP_FIN;
						end
						default: begin
							// clear the sums once the solver has its copy
							if (last_q) begin
								sums_q <= '0;
							end
							state_q <= A_IDLE;
						end
					endcase
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start && (state_q == A_IDLE)) begin
			x_q <= item.x_sample;
			y_q <= item.y_sample;
		end
		if ((state_q == A_RUN) && (step_q == STEP_SQ)) begin
			x2_q <= mul_p[MUL_W-1:0];
		end
	end

	`ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1, sums_q.count <= CNT_W'(MAX_SAMPLES), "count beyond capacity")
	`ASSERT_NEXT(a_clear_after_fire, clk, arst_n, fire, (sums_q.count == '0) && !sums_q.overflow_seen, "sums not cleared after fit")

endmodule

// ----- design/lsf_solve.sv -----
// ----------------------------------------------------------------------------
// Cramer solver
// Sequences determinant terms, magnitudes and divisions through one adder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsf_solve import lsf_pkg::*; #(
	parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  sums_t     snap,
	input  logic      mode,
	input  logic      out_free,
	output logic      busy,
	output logic      res_valid,
	output out_item_t res
);

	localparam int unsigned AW    = DW + 2;
	localparam int unsigned DIV_N = DW + COEF_FRAC_BITS;
	localparam int unsigned CW    = $clog2(DIV_N);

	typedef enum logic [12:0] {
		ST_IDLE = 13'h0001,
		ST_LDA  = 13'h0002,
		ST_LDB  = 13'h0004,
		ST_MUL1 = 13'h0008,
		ST_LDC  = 13'h0010,
		ST_MUL2 = 13'h0020,
		ST_ACC  = 13'h0040,
		ST_NEXT = 13'h0080,
		ST_ABS  = 13'h0100,
		ST_DIV  = 13'h0200,
		ST_RND  = 13'h0400,
		ST_FIN  = 13'h0800,
		ST_DONE = 13'h1000
	} sol_state_t;

	sol_state_t              state_q;
	logic                    mode_q;
	logic [1:0]              col_q;
	logic [2:0]              perm_q;
	logic signed [OP_W-1:0]  pw_q [0:4];
	logic signed [OP_W-1:0]  rh_q [0:2];
	logic [DW-1:0]           mcand_q;
	logic [OP_W-1:0]         mplier_q;
	logic [DW-1:0]           prod_q;
	logic [CW-1:0]           cnt_q;
	logic                    sign_q;
	logic [DW-1:0]           acc_q;
	logic [DW-1:0]           det_q;
	logic                    det_neg_q;
	logic [DW-1:0]           num_q;
	logic                    num_neg_q;
	logic [DW-1:0]           rem_q;
	logic [COEF_W-1:0]       quo_q;
	logic                    high_q;
	logic                    rnd_q;
	logic [COEF_W-1:0]       c0_q, c1_q, c2_q;
	logic                    sing_q;
	logic                    drop_q;
	logic [CNT_W-1:0]        npts_q;

	logic [1:0]              row_sel;
	logic [1:0]              pcol;
	logic signed [OP_W-1:0]  val;
	logic                    val_neg;
	logic [OP_W-1:0]         val_mag;
	logic [AW-1:0]           add_a, add_b, add_y;
	logic                    add_sub;
	logic                    last_perm;
	logic [2:0]              next_perm;
	logic                    last_col;
	logic [DW-1:0]           abs_mag;
	logic [COEF_W:0]         rmag;
	logic                    rhigh;
	logic                    res_neg;
	logic [COEF_W-1:0]       coef;

	// pick one matrix element: the row follows the state, the column the term
	always_comb begin
		unique case (state_q)
			ST_LDB:  row_sel = 2'd1;
			ST_LDC:  row_sel = 2'd2;
			default: row_sel = 2'd0;
		endcase
		pcol = perm_col(perm_q, row_sel);
		if (!mode_q && (row_sel == 2'd2)) begin
			val = OP_W'(1);
		end else if (pcol == col_q) begin
			unique case (row_sel)
				2'd0:    val = rh_q[0];
				2'd1:    val = rh_q[1];
				default: val = rh_q[2];
			endcase
		end else begin
			val = pw_q[3'(row_sel) + 3'(pcol)];
		end
		val_neg = val[OP_W-1];
		val_mag = val_neg ? (~val + OP_W'(1)) : val;
	end

	// shared wide adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			ST_MUL1, ST_MUL2: begin
				add_a = AW'(prod_q);
				add_b = AW'(mcand_q);
			end
			ST_ACC: begin
				add_a   = {{2{acc_q[DW-1]}}, acc_q};
				add_b   = AW'(prod_q);
				add_sub = sign_q;
			end
			ST_ABS: begin
				add_b   = {{2{acc_q[DW-1]}}, acc_q};
				add_sub = 1'b1;
			end
			ST_DIV: begin
				add_a   = AW'({rem_q, num_q[DW-1]});
				add_b   = AW'(det_q);
				add_sub = 1'b1;
			end
			ST_RND: begin
				add_a   = AW'({rem_q, 1'b0});
				add_b   = AW'(det_q);
				add_sub = 1'b1;
			end
			ST_FIN: begin
				add_a = AW'(quo_q);
				add_b = AW'(rnd_q);
			end
			default: begin
				add_a = '0;
			end
		endcase
		add_y = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
	end

	// sequencing decisions and final saturation
	always_comb begin
		last_perm = mode_q ? (perm_q == PERM_LAST_QUAD) : (perm_q == PERM_LIN_2ND);
		next_perm = mode_q ? (perm_q + 3'd1) : PERM_LIN_2ND;
		last_col  = mode_q ? (col_q == COL_SQ) : (col_q == COL_LIN);
		abs_mag   = acc_q[DW-1] ? add_y[DW-1:0] : acc_q;
		rmag      = add_y[COEF_W:0];
		rhigh     = high_q | rmag[COEF_W];
		res_neg   = num_neg_q ^ det_neg_q;
		if (!res_neg) begin
			coef = (rhigh || rmag[COEF_W-1]) ? {1'b0, {(COEF_W-1){1'b1}}} : rmag[COEF_W-1:0];
		end else if (rhigh || (rmag[COEF_W-1:0] > {1'b1, {(COEF_W-1){1'b0}}})) begin
			coef = {1'b1, {(COEF_W-1){1'b0}}};
		end else begin
			coef = ~rmag[COEF_W-1:0] + COEF_W'(1);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE) && out_free;

	always_comb begin
		res                 = '0;
		res.coef_constant   = c0_q;
		res.coef_linear     = c1_q;
		res.coef_square     = c2_q;
		res.singular        = sing_q;
		res.dropped_samples = drop_q;
		res.point_count     = npts_q;
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= COL_DET;
			perm_q  <= PERM_FIRST;
			cnt_q   <= '0;
			mode_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						mode_q  <= mode;
						col_q   <= COL_DET;
						perm_q  <= PERM_FIRST;
						state_q <= ST_LDA;
					end
				end
				ST_LDA: state_q <= ST_LDB;
				ST_LDB: begin
					cnt_q   <= '0;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(OP_W - 1)) begin
						state_q <= ST_LDC;
					end
				end
				ST_LDC: begin
					cnt_q   <= '0;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(OP_W - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (!last_perm) begin
						perm_q  <= next_perm;
						state_q <= ST_LDA;
					end else if ((col_q == COL_DET) && (acc_q == '0)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					perm_q <= PERM_FIRST;
					cnt_q  <= '0;
					if (col_q == COL_DET) begin
						col_q   <= COL_CONST;
						state_q <= ST_LDA;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_N - 1)) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: state_q <= ST_FIN;
				ST_FIN: begin
					perm_q <= PERM_FIRST;
					if (last_col) begin
						state_q <= ST_DONE;
					end else begin
						col_q   <= col_q + 2'd1;
						state_q <= ST_LDA;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					pw_q[0] <= OP_W'(snap.count);
					pw_q[1] <= OP_W'(snap.sum_x);
					pw_q[2] <= OP_W'(snap.sum_x_sq);
					pw_q[3] <= OP_W'(snap.sum_x_cube);
					pw_q[4] <= OP_W'(snap.sum_x_fourth);
					rh_q[0] <= OP_W'(snap.sum_y);
					rh_q[1] <= OP_W'(snap.sum_xy);
					rh_q[2] <= OP_W'(snap.sum_x_sq_y);
					drop_q  <= snap.overflow_seen;
					npts_q  <= snap.count;
					acc_q   <= '0;
					c0_q    <= '0;
					c1_q    <= '0;
					c2_q    <= '0;
					sing_q  <= 1'b0;
				end
			end
			ST_LDA: begin
				mcand_q <= DW'(val_mag);
				sign_q  <= perm_neg(perm_q) ^ val_neg;
			end
			ST_LDB: begin
				mplier_q <= val_mag;
				prod_q   <= '0;
				sign_q   <= sign_q ^ val_neg;
			end
			ST_MUL1, ST_MUL2: begin
				// shift-add: one multiplier bit per cycle
				if (mplier_q[0]) begin
					prod_q <= add_y[DW-1:0];
				end
				mcand_q  <= {mcand_q[DW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[OP_W-1:1]};
			end
			ST_LDC: begin
				mcand_q  <= prod_q;
				mplier_q <= val_mag;
				prod_q   <= '0;
				sign_q   <= sign_q ^ val_neg;
			end
			ST_ACC: acc_q <= add_y[DW-1:0];
			ST_NEXT: begin
				if (last_perm && (col_q == COL_DET) && (acc_q == '0)) begin
					sing_q <= 1'b1;
				end
			end
			ST_ABS: begin
				if (col_q == COL_DET) begin
					det_q     <= abs_mag;
					det_neg_q <= acc_q[DW-1];
				end else begin
					num_q     <= abs_mag;
					num_neg_q <= acc_q[DW-1];
				end
				acc_q  <= '0;
				rem_q  <= '0;
				quo_q  <= '0;
				high_q <= 1'b0;
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (!add_y[AW-1]) begin
					rem_q <= add_y[DW-1:0];
				end else begin
					rem_q <= {rem_q[DW-2:0], num_q[DW-1]};
				end
				num_q  <= {num_q[DW-2:0], 1'b0};
				quo_q  <= {quo_q[COEF_W-2:0], ~add_y[AW-1]};
				high_q <= high_q | quo_q[COEF_W-1];
			end
			ST_RND: rnd_q <= ~add_y[AW-1];
			ST_FIN: begin
				unique case (col_q)
					COL_CONST: c0_q <= coef;
					COL_LIN:   c1_q <= coef;
					COL_SQ:    c2_q <= coef;
					default:   c0_q <= c0_q;
				endcase
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	`ASSERT_IMPL(a_singular_zero, clk, arst_n, res_valid && res.singular, (res.coef_constant == '0) && (res.coef_linear == '0) && (res.coef_square == '0), "singular fit with nonzero coefficients")
	`ASSERT_IMPL(a_linear_no_square, clk, arst_n, res_valid && !mode_q, res.coef_square == '0, "square term in linear fit")

endmodule

// ----- dv/lsf_fit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Curve fit checker
// Watches the sample, result and mode ports, keeps its own exact power sums,
// solves each data set with wide integers and compares every result item.
// ----------------------------------------------------------------------------
module lsf_fit_checker import lsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        mismatches,
	output int        pending,
	output int        fits,
	output int        singular_fits,
	output int        dropped_fits
);

	typedef logic signed [255:0] wide_t;

	localparam int unsigned CAPACITY = DEF_MAX_SAMPLES;
	localparam int unsigned FRAC     = DEF_COEF_FRAC_BITS;

	logic      mode_q;
	int        n_pts;
	longint    s_x, s_y, s_xy, s_xx, s_xxy, s_x3, s_x4;
	logic      lost;
	out_item_t fit_queue[$];

	// round num/den scaled by 2^FRAC, ties away from zero, saturate to 64 bits
	function automatic logic signed [63:0] to_fixed(input wide_t num, input wide_t den);
		wide_t n, d, mag;
		logic  neg;
		neg = (num < 0) != (den < 0);
		n   = (num < 0) ? -num : num;
		d   = (den < 0) ? -den : den;
		mag = ((n <<< (FRAC + 1)) + d) / (d <<< 1);
		if (!neg)
			return (mag > wide_t'(64'sh7FFF_FFFF_FFFF_FFFF)) ? 64'sh7FFF_FFFF_FFFF_FFFF
				: mag[63:0];
		if (mag > (wide_t'(1) <<< 63))
			return 64'sh8000_0000_0000_0000;
		return -mag[63:0];
	endfunction

	function automatic wide_t det3(input wide_t a, b, c, d, e, f, g, h, i);
		return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
	endfunction

	function automatic out_item_t solve_fit();
		out_item_t r;
		wide_t n, sx, sy, sxy, sxx, sxxy, sx3, sx4, dt;
		n    = n_pts;
		sx   = s_x;
		sy   = s_y;
		sxy  = s_xy;
		sxx  = s_xx;
		sxxy = s_xxy;
		sx3  = s_x3;
		sx4  = s_x4;
		r = '0;
		r.dropped_samples = lost;
		r.point_count     = n_pts[10:0];
		if (!mode_q) begin
			dt = n * sxx - sx * sx;
			if (dt == 0) begin
				r.singular = 1'b1;
			end else begin
				r.coef_constant = to_fixed(sxx * sy - sx * sxy, dt);
				r.coef_linear   = to_fixed(n * sxy - sx * sy, dt);
			end
		end else begin
			dt = det3(n, sx, sxx, sx, sxx, sx3, sxx, sx3, sx4);
			if (dt == 0) begin
				r.singular = 1'b1;
			end else begin
				r.coef_constant = to_fixed(det3(sy, sx, sxx, sxy, sxx, sx3, sxxy, sx3, sx4), dt);
				r.coef_linear   = to_fixed(det3(n, sy, sxx, sx, sxy, sx3, sxx, sxxy, sx4), dt);
				r.coef_square   = to_fixed(det3(n, sx, sy, sx, sxx, sxy, sxx, sx3, sxxy), dt);
			end
		end
		return r;
	endfunction

	assign pending = fit_queue.size();

	// track mode, accumulate samples, predict and compare results
	always @(posedge clk or negedge arst_n) begin
		longint    x, y;
		out_item_t want;
		if (!arst_n) begin
			mode_q <= 1'b0;
			n_pts = 0;
			s_x = 0; s_y = 0; s_xy = 0; s_xx = 0; s_xxy = 0; s_x3 = 0; s_x4 = 0;
			lost = 1'b0;
			fit_queue.delete();
			mismatches <= 0;
			fits <= 0;
			singular_fits <= 0;
			dropped_fits <= 0;
		end else begin
			if (cfg_wr_en)
				mode_q <= cfg_wr_data;
			if (in_valid && in_ready) begin
				x = in_data.x_sample;
				y = in_data.y_sample;
				if (n_pts < CAPACITY) begin
					n_pts++;
					s_x   += x;
					s_y   += y;
					s_xy  += x * y;
					s_xx  += x * x;
					s_xxy += x * x * y;
					s_x3  += x * x * x;
					s_x4  += x * x * x * x;
				end else begin
					lost = 1'b1;
				end
				if (in_data.last_sample) begin
					fit_queue.push_back(solve_fit());
					n_pts = 0;
					s_x = 0; s_y = 0; s_xy = 0; s_xx = 0; s_xxy = 0; s_x3 = 0; s_x4 = 0;
					lost = 1'b0;
				end
			end
			if (out_valid && out_ready) begin
				if (fit_queue.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result item %h", out_data);
					mismatches <= mismatches + 1;
				end else begin
					want = fit_queue.pop_front();
					fits <= fits + 1;
					if (want.singular)
						singular_fits <= singular_fits + 1;
					if (want.dropped_samples)
						dropped_fits <= dropped_fits + 1;
					if (out_data.coef_constant !== want.coef_constant ||
						out_data.coef_linear !== want.coef_linear ||
						out_data.coef_square !== want.coef_square ||
						out_data.singular !== want.singular ||
						out_data.dropped_samples !== want.dropped_samples ||
						out_data.point_count !== want.point_count) begin
						if (mismatches < 10) begin
							$display("fit mismatch: expected c0=%h c1=%h c2=%h sing=%b drop=%b n=%0d",
								want.coef_constant, want.coef_linear, want.coef_square,
								want.singular, want.dropped_samples, want.point_count);
							$display("              actual   c0=%h c1=%h c2=%h sing=%b drop=%b n=%0d",
								out_data.coef_constant, out_data.coef_linear,
								out_data.coef_square, out_data.singular,
								out_data.dropped_samples, out_data.point_count);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Curve fit testbench
// Feeds directed and random data sets in both fit modes under several
// idling patterns, including a long receiver hold-off; the checker judges.
// ----------------------------------------------------------------------------
module tb;
	import lsf_pkg::*;

	localparam int unsigned FIT_LINE = 0;
	localparam int unsigned FIT_QUAD = 1;

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic      cfg_wr_data;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	int        mismatches, pending, fits, singular_fits, dropped_fits;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_cycles;
	int        sample_total;

	least_squares_curve_fit_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	lsf_fit_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.fits         (fits),
		.singular_fits(singular_fits),
		.dropped_fits (dropped_fits)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offer one sample and hold it until taken
	task automatic send_sample(input logic signed [11:0] x, input logic signed [11:0] y,
		input logic last);
		in_item_t it;
		it.x_sample    = x;
		it.y_sample    = y;
		it.last_sample = last;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sample_total++;
	endtask

	// drain, let the block settle, then write the mode register
	task automatic set_fit_mode(input int unsigned m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m[0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one data set of random content; narrow x now and then to hit singular fits
	task automatic send_random_set(input int len);
		int narrow;
		narrow = $urandom_range(3);
		for (int i = 0; i < len; i++) begin
			if (narrow == 0)
				send_sample(12'($urandom_range(6) - 3), 12'($urandom), i == len - 1);
			else
				send_sample(12'($urandom), 12'($urandom), i == len - 1);
		end
	endtask

	task automatic run_phase(input int items, input int idle, input int stall);
		int sent, len;
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(2, 40);
			send_random_set(len);
			sent += len;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		sample_total   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, straight line: single point, extremes, vertical line
		send_sample(-2048, 2047, 1'b1);
		send_sample(-2048, -2048, 1'b0);
		send_sample(2047, 2047, 1'b1);
		send_sample(5, 1, 1'b0);
		send_sample(5, -7, 1'b1);
		send_sample(0, 0, 1'b0);
		send_sample(1, 3, 1'b0);
		send_sample(2, 4, 1'b1);
		send_sample(-1, 0, 1'b0);
		send_sample(1, 1, 1'b1);

		// directed, quadratic: exact parabola, two points, extremes
		set_fit_mode(FIT_QUAD);
		send_sample(-1, 1, 1'b0);
		send_sample(0, 0, 1'b0);
		send_sample(1, 1, 1'b0);
		send_sample(2, 4, 1'b1);
		send_sample(3, 9, 1'b0);
		send_sample(-3, 2, 1'b1);
		send_sample(-2048, 2047, 1'b0);
		send_sample(2047, -2048, 1'b0);
		send_sample(0, 2047, 1'b1);
		send_sample(0, 1, 1'b0);
		send_sample(1, 0, 1'b0);
		send_sample(2, 0, 1'b1);

		// random phases over both modes and idling patterns
		set_fit_mode(FIT_LINE);
		run_phase(120, 0, 0);
		set_fit_mode(FIT_QUAD);
		run_phase(120, 65, 0);
		set_fit_mode(FIT_LINE);
		run_phase(120, 0, 65);
		set_fit_mode(FIT_QUAD);
		run_phase(120, 20, 20);

		// hold the receiver while samples keep coming so the input stalls
		hold_cycles <= 12000;
		run_phase(100, 0, 0);

		// capacity: corner sums then dropped samples
		set_fit_mode(FIT_LINE);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 1026; i++)
			send_sample(-2048, -2048, i == 1025);

		run_phase(100, 20, 20);

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4000) @(posedge clk);

		$display("covered %0d samples and %0d fits in both modes", sample_total, fits);
		$display("%0d fits singular, %0d with dropped samples", singular_fits, dropped_fits);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// give up well beyond the slowest correct run
	initial begin
		#600_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
